### src/hdrtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrtm_pkg
// Shared constants, widths and the gamma threshold table of the tone mapper.
// ----------------------------------------------------------------------------
package hdrtm_pkg;

  localparam int IN_FRAC_BITS     = 16;
  localparam int IN_INT_BITS      = 8;
  localparam int GAMMA_INDEX_BITS = 12;

  localparam int SAMPLE_W = IN_INT_BITS + IN_FRAC_BITS;
  localparam int X_W      = IN_FRAC_BITS + 4;
  localparam int MID_W    = IN_FRAC_BITS + 12;
  localparam int PROD_W   = 2 * IN_FRAC_BITS + 14;
  localparam int IDX_W    = GAMMA_INDEX_BITS + 1;

  // Lane pipeline: cap, linear terms, products, saturation test,
  // one stage per quotient bit, one stage per gamma search bit.
  localparam int LANE_LAT = 4 + GAMMA_INDEX_BITS + 8;

  localparam logic [X_W-1:0]    X_CAP   = X_W'(8) << IN_FRAC_BITS;
  localparam logic [MID_W-1:0]  ONE_MID = MID_W'(1) << IN_FRAC_BITS;
  localparam logic [PROD_W-1:0] DEN_K   = PROD_W'(14) << (2 * IN_FRAC_BITS);
  localparam logic [IDX_W-1:0]  IDX_FULL = IDX_W'(1) << GAMMA_INDEX_BITS;

  localparam int REG_HDR_MODE      = 0;
  localparam int REG_CHANNEL_COUNT = 1;

  typedef logic [IDX_W-1:0] thr_table_t [0:255];

  // Smallest index whose gamma-corrected byte reaches c:
  // idx^5 * 255^11 >= c^11 * 2^(5G).
  function automatic thr_table_t build_thr();
    thr_table_t   t;
    logic [199:0] full;
    logic [199:0] lhs;
    logic [199:0] rhs;
    int           lo;
    int           hi;
    int           mid;
    full = 200'(1);
    for (int k = 0; k < 11; k++) full = full * 200'(255);
    t[0] = '0;
    for (int c = 1; c < 256; c++) begin
      lo = 0;
      hi = (1 << GAMMA_INDEX_BITS) + 1;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        lhs = full;
        for (int k = 0; k < 5; k++) lhs = lhs * 200'(mid);
        rhs = 200'(1);
        for (int k = 0; k < 11; k++) rhs = rhs * 200'(c);
        rhs = rhs << (5 * GAMMA_INDEX_BITS);
        if (lhs >= rhs) hi = mid;
        else lo = mid + 1;
      end
      t[c] = IDX_W'(lo);
    end
    return t;
  endfunction

  localparam thr_table_t GAMMA_THR = build_thr();

endpackage

### src/hdrtm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrtm_lane
// One channel of the tone mapper: rational curve, pipelined divider and
// pipelined gamma table search.
// ----------------------------------------------------------------------------
module hdrtm_lane (
  input  logic                   clk,
  input  logic                   en,
  input  logic [hdrtm_pkg::SAMPLE_W-1:0] sample,
  output logic [7:0]             pixel
);
  import hdrtm_pkg::*;

  logic [X_W-1:0]    x1, x2;
  logic [MID_W-1:0]  a2, b2;
  logic [PROD_W-1:0] num3, den3;
  logic [PROD_W:0]   rem [0:GAMMA_INDEX_BITS];
  logic [PROD_W-1:0] den [0:GAMMA_INDEX_BITS];
  logic [GAMMA_INDEX_BITS-1:0] quo [0:GAMMA_INDEX_BITS];
  logic              sat [0:GAMMA_INDEX_BITS];
  logic [IDX_W-1:0]  idx [0:8];
  logic [7:0]        byt [0:8];

  // Stage 1: cap; the curve is already above one there.
  always_ff @(posedge clk) begin
    if (en) begin
      if ((SAMPLE_W + 1)'(sample) > (SAMPLE_W + 1)'(X_CAP)) x1 <= X_CAP;
      else x1 <= X_W'(sample);
    end
  end

  // Stage 2: linear terms 251x + 3S and 243x + 59S.
  always_ff @(posedge clk) begin
    if (en) begin
      x2 <= x1;
      a2 <= MID_W'(x1) * MID_W'(251) + MID_W'(3) * ONE_MID;
      b2 <= MID_W'(x1) * MID_W'(243) + MID_W'(59) * ONE_MID;
    end
  end

  // Stage 3: numerator and denominator.
  always_ff @(posedge clk) begin
    if (en) begin
      num3 <= PROD_W'(PROD_W'(x2) * PROD_W'(a2));
      den3 <= PROD_W'(PROD_W'(x2) * PROD_W'(b2)) + DEN_K;
    end
  end

  // Stage 4: a ratio of one or more saturates the index.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, num3};
      den[0] <= den3;
      quo[0] <= '0;
      sat[0] <= (num3 >= den3);
    end
  end

  for (genvar i = 0; i < GAMMA_INDEX_BITS; i++) begin : g_div
    logic [PROD_W:0] sh;
    assign sh = {rem[i][PROD_W-1:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        den[i+1] <= den[i];
        sat[i+1] <= sat[i];
        if (sh >= {1'b0, den[i]}) begin
          rem[i+1] <= sh - {1'b0, den[i]};
          quo[i+1] <= {quo[i][GAMMA_INDEX_BITS-2:0], 1'b1};
        end else begin
          rem[i+1] <= sh;
          quo[i+1] <= {quo[i][GAMMA_INDEX_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign idx[0] = sat[GAMMA_INDEX_BITS] ? IDX_FULL : {1'b0, quo[GAMMA_INDEX_BITS]};
  assign byt[0] = '0;

  // Binary search for the largest byte whose threshold the index reaches.
  for (genvar j = 0; j < 8; j++) begin : g_gam
    logic [7:0] cand;
    assign cand = byt[j] | (8'(1) << (7 - j));
    always_ff @(posedge clk) begin
      if (en) begin
        idx[j+1] <= idx[j];
        byt[j+1] <= (GAMMA_THR[cand] <= idx[j]) ? cand : byt[j];
      end
    end
  end

  assign pixel = byt[8];

endmodule

### src/hdr_tonemap_gamma_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_tonemap_gamma_pixel
// Pixel converter from HDR fixed point or bytes to 8-bit display RGB.
// ----------------------------------------------------------------------------
// Input words arrive on the s_ channel, one pixel per word: red, green and
// blue samples of 24 bits each. Result words leave on the m_ channel as a
// red, green, blue byte triple. Three lanes run the tone curve, divider and
// gamma search side by side; a merging stage picks tone-mapped or pass-through
// bytes and copies the last present channel into absent ones.
// The block takes one word per clock while the receiver does not stall. Each
// lane holds a 12-stage divider and an 8-stage gamma table search; the merged
// result is registered on m_tdata. When the receiver stalls, the whole
// pipeline holds and s_tready drops; it rises again as soon as m_tready is
// seen. Reset empties the pipeline and sets hdr_mode to 0 and channel_count
// to 3. The cfg_ port writes the selected register; write it only while idle.
// ----------------------------------------------------------------------------
module hdr_tonemap_gamma_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // sample_red, sample_green, sample_blue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // out_red, out_green, out_blue
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);
  import hdrtm_pkg::*;

  logic       hdr_mode;
  logic [2:0] channel_count;
  logic       en;
  logic       vld [0:LANE_LAT-1];
  logic [23:0] ldr [0:LANE_LAT-1];
  logic [7:0] px [0:2];
  logic [7:0] sel [0:2];
  logic [7:0] grn, blu;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_mode      <= 1'b0;
      channel_count <= 3'd3;
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_HDR_MODE)) hdr_mode <= cfg_data[0];
      else channel_count <= cfg_data;
    end
  end

  assign en       = !(m_tvalid && !m_tready);
  assign s_tready = en;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    hdrtm_lane u_lane (
      .clk    (clk),
      .en     (en),
      .sample (s_tdata[l*24 +: 24]),
      .pixel  (px[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < LANE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ldr[0] <= {s_tdata[55:48], s_tdata[31:24], s_tdata[7:0]};
      for (int i = 1; i < LANE_LAT; i++) ldr[i] <= ldr[i-1];
    end
  end

  // Merge: choose the source per lane, then fill absent channels.
  always_comb begin
    for (int l = 0; l < 3; l++) sel[l] = hdr_mode ? px[l] : ldr[LANE_LAT-1][l*8 +: 8];
    grn = (channel_count >= 3'd2) ? sel[1] : sel[0];
    blu = (channel_count >= 3'd3) ? sel[2] : grn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {blu, grn, sel[0]};
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the HDR tone-map and gamma pixel converter.
// ----------------------------------------------------------------------------
// A directed table covers the pass-through bytes, channel counts 0 to 4 and 7
// and the tone-curve extremes. Random pixels follow under several register
// settings and idle patterns on both stream sides. Each result word is
// compared with the oldest expected word, typed in the table or predicted.
// The predictor does exact integer tone mapping and a gamma threshold search.
// ----------------------------------------------------------------------------
module tb_top;
  import hdrtm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [2:0]  cfg_data = '0;

  hdr_tonemap_gamma_pixel dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    bit          hdr;
    logic [2:0]  cnt;
    logic [23:0] r, g, b;
    bit          typed;
    logic [23:0] rgb;
  } pix_row_t;

  typedef struct {
    bit          typed;
    logic [23:0] rgb;
  } typed_exp_t;

  logic [23:0] rgb_due_q[$];
  typed_exp_t  typed_q[$];
  logic [IDX_W-1:0] thr [0:255];

  bit         cur_hdr;
  logic [2:0] cur_cnt;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  long_hold = 1'b0;
  int  n_sent = 0;
  int  n_done = 0;
  int  n_bad = 0;
  int  n_hdr = 0;
  int  cycles = 0;

  // Smallest gamma index whose byte reaches c, exact big-integer search.
  task automatic build_thresholds();
    logic [199:0] full, lhs, rhs;
    int lo, hi, mid;
    full = 200'(1);
    for (int k = 0; k < 11; k++) full = full * 200'(255);
    thr[0] = '0;
    for (int c = 1; c < 256; c++) begin
      lo = 0;
      hi = (1 << GAMMA_INDEX_BITS) + 1;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        lhs = full;
        for (int k = 0; k < 5; k++) lhs = lhs * 200'(mid);
        rhs = 200'(1);
        for (int k = 0; k < 11; k++) rhs = rhs * 200'(c);
        rhs = rhs << (5 * GAMMA_INDEX_BITS);
        if (lhs >= rhs) hi = mid;
        else lo = mid + 1;
      end
      thr[c] = IDX_W'(lo);
    end
  endtask

  function automatic logic [7:0] tone_byte(logic [23:0] x);
    longint unsigned s, v, num, den, r, q;
    logic [7:0] b;
    s = 64'd1 << IN_FRAC_BITS;
    v = x;
    if (v > 8 * s) v = 8 * s;
    num = v * (251 * v + 3 * s);
    den = v * (243 * v + 59 * s) + 14 * s * s;
    if (num >= den) begin
      q = 64'd1 << GAMMA_INDEX_BITS;
    end else begin
      r = num;
      q = 0;
      for (int i = 0; i < GAMMA_INDEX_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
    end
    b = 8'd0;
    for (int c = 1; c < 256; c++)
      if (longint'(thr[c]) <= q) b = 8'(c);
    return b;
  endfunction

  function automatic logic [23:0] predict_rgb(logic [71:0] d);
    logic [7:0] px [0:2];
    int n;
    n = (cur_cnt == 0) ? 1 : (cur_cnt > 3) ? 3 : int'(cur_cnt);
    for (int j = 0; j < 3; j++) begin
      if (j < n) px[j] = cur_hdr ? tone_byte(d[24*j +: 24]) : d[24*j +: 8];
      else px[j] = px[n-1];
    end
    return {px[2], px[1], px[0]};
  endfunction

  // Acceptance and result monitor.
  always @(posedge clk) begin
    typed_exp_t t;
    logic [23:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        t = typed_q.pop_front();
        rgb_due_q.push_back(t.typed ? t.rgb : predict_rgb(s_tdata));
        if (cur_hdr) n_hdr++;
      end
      if (m_tvalid && m_tready) begin
        if (rgb_due_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected word %h", m_tdata);
        end else begin
          want = rgb_due_q.pop_front();
          if (want !== m_tdata) begin
            n_bad++;
            if (n_bad <= 10)
              $display("word %0d: red exp %h got %h, green exp %h got %h, blue exp %h got %h",
                       n_done, want[7:0], m_tdata[7:0], want[15:8], m_tdata[15:8],
                       want[23:16], m_tdata[23:16]);
          end
        end
        n_done++;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  initial begin
    int held;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        for (held = 0; held < 300; held++) @(posedge clk);
        long_hold = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b,
                            bit typed, logic [23:0] rgb);
    typed_exp_t t;
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    t.typed = typed;
    t.rgb = rgb;
    typed_q.push_back(t);
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (n_done != n_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(bit hdr, logic [2:0] cnt);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= 1'(REG_HDR_MODE);
    cfg_data <= {2'b00, hdr};
    @(posedge clk);
    cur_hdr = hdr;
    cfg_index <= 1'(REG_CHANNEL_COUNT);
    cfg_data <= cnt;
    @(posedge clk);
    cur_cnt = cnt;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(4))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 9 << IN_FRAC_BITS));
      2: return 24'($urandom_range(0, 1 << IN_FRAC_BITS));
      3: return 24'($urandom_range(0, 4095));
      default: return ($urandom_range(1)) ? 24'hFFFFFF : 24'h000000;
    endcase
  endfunction

  pix_row_t rows [] = '{
    '{0, 3'd3, 24'hABCD12, 24'h000000, 24'hFFFFFF, 1, 24'hFF0012},
    '{0, 3'd3, 24'h0000FF, 24'hFFFF00, 24'h123456, 1, 24'h5600FF},
    '{0, 3'd1, 24'h000080, 24'h000011, 24'h000022, 1, 24'h808080},
    '{0, 3'd2, 24'h000011, 24'h000022, 24'h000033, 1, 24'h222211},
    '{0, 3'd0, 24'h000044, 24'h000055, 24'h000066, 1, 24'h444444},
    '{0, 3'd4, 24'h000001, 24'h000002, 24'h000003, 1, 24'h030201},
    '{0, 3'd7, 24'hFFFFFE, 24'h7F7F7F, 24'h000000, 1, 24'h007FFE},
    '{1, 3'd3, 24'h000000, 24'h000000, 24'h000000, 1, 24'h000000},
    '{1, 3'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 24'hFFFFFF},
    '{1, 3'd3, 24'h080000, 24'h080001, 24'h800000, 1, 24'hFFFFFF},
    '{1, 3'd3, 24'h010000, 24'h000001, 24'h07FFFF, 0, 24'h0},
    '{1, 3'd3, 24'h004000, 24'h000800, 24'h020000, 0, 24'h0},
    '{1, 3'd3, 24'h000100, 24'h008000, 24'h030000, 0, 24'h0},
    '{1, 3'd1, 24'h00C000, 24'hFFFFFF, 24'h000000, 0, 24'h0},
    '{1, 3'd2, 24'h002000, 24'h018000, 24'hFFFFFF, 0, 24'h0},
    '{1, 3'd0, 24'h010000, 24'h000000, 24'hFFFFFF, 0, 24'h0},
    '{1, 3'd4, 24'h000010, 24'h001000, 24'h100000, 0, 24'h0},
    '{1, 3'd7, 24'h006000, 24'hFFFFFF, 24'h000000, 0, 24'h0}
  };

  initial begin
    bit hdr;
    logic [2:0] cnt;
    build_thresholds();
    cur_hdr = 1'b0;
    cur_cnt = 3'd3;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].hdr != cur_hdr || rows[i].cnt != cur_cnt)
        set_regs(rows[i].hdr, rows[i].cnt);
      send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].typed, rows[i].rgb);
    end

    for (int p = 0; p < 8; p++) begin
      hdr = (p % 3 != 2);
      case (p)
        0, 5: cnt = 3'd3;
        1: cnt = 3'd1;
        2: cnt = 3'd2;
        3: cnt = 3'd0;
        4: cnt = 3'd7;
        6: cnt = 3'd4;
        default: cnt = 3'($urandom_range(7));
      endcase
      set_regs(hdr, cnt);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      if (p == 4) long_hold = 1'b1;
      for (int k = 0; k < 205; k++)
        send_pixel(rand_sample(), rand_sample(), rand_sample(), 0, 24'h0);
    end

    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (n_done != n_sent && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (rgb_due_q.size() != 0) begin
      n_bad++;
      $display("%0d expected words never arrived", rgb_due_q.size());
    end
    $display("pixels sent %0d (%0d tone-mapped), words checked %0d, mismatches %0d",
             n_sent, n_hdr, n_done, n_bad);
    $display("covered both modes, channel counts 0 to 4 and 7, stalls and a long hold-off");
    if (n_bad == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
